>>> src/cfr_pkg.sv
package cfr_pkg;

    // Data widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 20;
    localparam int COEF_FRAC  = 16;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int RND_W      = ACC_W - COEF_FRAC;

    // Configuration register file
    localparam int NUM_COEF   = 6;
    localparam int CIDX_W     = 3;

    localparam logic [CIDX_W-1:0] REG_GAIN_ONE = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FB1_ONE  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_FB2_ONE  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_GAIN_TWO = 3'd3;
    localparam logic [CIDX_W-1:0] REG_FB1_TWO  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_FB2_TWO  = 3'd5;

    // Program counter
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_TEST  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CLEAR = 4'd1;
    localparam logic [STEP_W-1:0] STEP_G1    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_A1    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_B1    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_C1    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_S1    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_G2    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_A2    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_B2    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_C2    = 4'd10;
    localparam logic [STEP_W-1:0] STEP_S2    = 4'd11;

    // Multiplier operand select
    typedef enum logic [2:0] {
        OPA_IN,
        OPA_MID,
        OPA_P1_ONE,
        OPA_P2_ONE,
        OPA_P1_TWO,
        OPA_P2_TWO
    } opa_t;

    // Accumulator operation on the registered product
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_SUB
    } acc_op_t;

    // Round, saturate and write back
    typedef enum logic [1:0] {
        ST_NONE,
        ST_ONE,
        ST_TWO
    } store_t;

    typedef struct packed {
        logic                jmp_noseg;
        logic [STEP_W-1:0]   jmp_target;
        logic                clr_hist;
        opa_t                opa;
        logic [CIDX_W-1:0]   coef;
        acc_op_t             acc_op;
        store_t              store;
        logic                last;
    } ctrl_word_t;

    // Microprogram: one control word per step
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{jmp_noseg: 1'b0, jmp_target: STEP_TEST, clr_hist: 1'b0, opa: OPA_IN,
              coef: REG_GAIN_ONE, acc_op: ACC_HOLD, store: ST_NONE, last: 1'b0};
        case (step)
            STEP_TEST:
            begin
                w.jmp_noseg  = 1'b1;
                w.jmp_target = STEP_G1;
            end
            STEP_CLEAR: w.clr_hist = 1'b1;
            STEP_G1:
            begin
                w.opa  = OPA_IN;
                w.coef = REG_GAIN_ONE;
            end
            STEP_A1:
            begin
                w.acc_op = ACC_LOAD;
                w.opa    = OPA_P1_ONE;
                w.coef   = REG_FB1_ONE;
            end
            STEP_B1:
            begin
                w.acc_op = ACC_SUB;
                w.opa    = OPA_P2_ONE;
                w.coef   = REG_FB2_ONE;
            end
            STEP_C1: w.acc_op = ACC_SUB;
            STEP_S1: w.store  = ST_ONE;
            STEP_G2:
            begin
                w.opa  = OPA_MID;
                w.coef = REG_GAIN_TWO;
            end
            STEP_A2:
            begin
                w.acc_op = ACC_LOAD;
                w.opa    = OPA_P1_TWO;
                w.coef   = REG_FB1_TWO;
            end
            STEP_B2:
            begin
                w.acc_op = ACC_SUB;
                w.opa    = OPA_P2_TWO;
                w.coef   = REG_FB2_TWO;
            end
            STEP_C2: w.acc_op = ACC_SUB;
            STEP_S2:
            begin
                w.store = ST_TWO;
                w.last  = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

endpackage

>>> src/cascaded_formant_resonator.sv
// Channel   Signals                              Direction  Transfer when
// input     sample_in, segment_start             in         in_valid && in_ready
// output    sample_out                           out        out_valid && out_ready
// config    cfg_index, cfg_data                  in         cfg_write
//
// Each sample runs an 11-step microprogram (12 steps when segment_start is high)
// on one shared 16x20 multiplier: six products, two round and saturate steps.
// A new sample is accepted only once the previous one has finished its program;
// the result becomes valid when the final store step completes.
// Reset clears coefficients, history and the handshake flags.
// The last step holds while the previous result has not been transferred.
module cascaded_formant_resonator
    import cfr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [CIDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]          cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       segment_start,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out
);

    localparam logic signed [RND_W-1:0] SAT_HI =
        {{(RND_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [RND_W-1:0] SAT_LO =
        {{(RND_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] RND_HALF =
        ACC_W'(1) << (COEF_FRAC - 1);

    logic signed [COEF_W-1:0]   coef_reg [NUM_COEF];
    logic                       busy_reg;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       seg_reg;
    logic signed [SAMPLE_W-1:0] mid_reg;
    logic signed [SAMPLE_W-1:0] p1_one_reg, p2_one_reg, p1_two_reg, p2_two_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_reg;

    ctrl_word_t                 cw;
    logic signed [SAMPLE_W-1:0] opa;
    logic signed [COEF_W-1:0]   opc;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc_rnd;
    logic signed [RND_W-1:0]    scaled;
    logic signed [SAMPLE_W-1:0] sat_val;
    logic                       stall;

    assign cw         = ucode(step_reg);
    assign in_ready   = !busy_reg;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

    // Select multiplier operands
    always_comb
    begin
        case (cw.opa)
            OPA_IN:     opa = x_reg;
            OPA_MID:    opa = mid_reg;
            OPA_P1_ONE: opa = p1_one_reg;
            OPA_P2_ONE: opa = p2_one_reg;
            OPA_P1_TWO: opa = p1_two_reg;
            OPA_P2_TWO: opa = p2_two_reg;
            default:    opa = '0;
        endcase
        case (cw.coef)
            REG_GAIN_ONE: opc = coef_reg[0];
            REG_FB1_ONE:  opc = coef_reg[1];
            REG_FB2_ONE:  opc = coef_reg[2];
            REG_GAIN_TWO: opc = coef_reg[3];
            REG_FB1_TWO:  opc = coef_reg[4];
            REG_FB2_TWO:  opc = coef_reg[5];
            default:      opc = '0;
        endcase
    end

    // Round half up, drop fraction bits, saturate to sample range
    always_comb
    begin
        prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        acc_rnd  = acc_reg + RND_HALF;
        scaled   = acc_rnd[ACC_W-1:COEF_FRAC];
        if (scaled > SAT_HI)
            sat_val = SAT_HI[SAMPLE_W-1:0];
        else if (scaled < SAT_LO)
            sat_val = SAT_LO[SAMPLE_W-1:0];
        else
            sat_val = scaled[SAMPLE_W-1:0];
    end

    // Sequence the program: hold the final step until the output slot is free
    always_comb
    begin
        stall = (cw.store == ST_TWO) && out_valid_reg && !out_ready;
        if (stall)
            step_next = step_reg;
        else if (cw.jmp_noseg && !seg_reg)
            step_next = cw.jmp_target;
        else
            step_next = step_reg + STEP_W'(1);
    end

    // Write configuration registers; ignore indexes past the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
                coef_reg[i] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAIN_ONE: coef_reg[0] <= cfg_data;
                REG_FB1_ONE:  coef_reg[1] <= cfg_data;
                REG_FB2_ONE:  coef_reg[2] <= cfg_data;
                REG_GAIN_TWO: coef_reg[3] <= cfg_data;
                REG_FB1_TWO:  coef_reg[4] <= cfg_data;
                REG_FB2_TWO:  coef_reg[5] <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Control: accept, step, deliver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_TEST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (busy_reg && !stall && (cw.store == ST_TWO))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (in_valid)
                begin
                    busy_reg <= 1'b1;
                    step_reg <= STEP_TEST;
                end
            end
            else if (!stall)
            begin
                step_reg <= step_next;
                if (cw.last)
                    busy_reg <= 1'b0;
            end
        end
    end

    // History: clear on segment start, shift on each section store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_one_reg <= '0;
            p2_one_reg <= '0;
            p1_two_reg <= '0;
            p2_two_reg <= '0;
        end
        else if (busy_reg && !stall)
        begin
            if (cw.clr_hist)
            begin
                p1_one_reg <= '0;
                p2_one_reg <= '0;
                p1_two_reg <= '0;
                p2_two_reg <= '0;
            end
            else if (cw.store == ST_ONE)
            begin
                p2_one_reg <= p1_one_reg;
                p1_one_reg <= sat_val;
            end
            else if (cw.store == ST_TWO)
            begin
                p2_two_reg <= p1_two_reg;
                p1_two_reg <= sat_val;
            end
        end
    end

    // Datapath: capture input, multiply, accumulate, hold results
    always_ff @(posedge clk)
    begin
        if (!busy_reg && in_valid)
        begin
            x_reg   <= sample_in;
            seg_reg <= segment_start;
        end
        prod_reg <= PROD_W'(opa) * PROD_W'(opc);
        if (busy_reg && !stall)
        begin
            case (cw.acc_op)
                ACC_LOAD: acc_reg <= prod_ext;
                ACC_SUB:  acc_reg <= acc_reg - prod_ext;
                default:  acc_reg <= acc_reg;
            endcase
            if (cw.store == ST_ONE)
                mid_reg <= sat_val;
            if (cw.store == ST_TWO)
                out_reg <= sat_val;
        end
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench
    import cfr_pkg::*;
();

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_TOP    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_BOTTOM = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [COEF_W-1:0]   COEF_TOP      = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0]   COEF_BOTTOM   = {1'b1, {(COEF_W-1){1'b0}}};
    localparam int UNITY          = 1 << COEF_FRAC;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int STALL_CYCLES   = 300;
    localparam int REPORT_LIMIT   = 10;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       cfg_write     = 1'b0;
    logic [CIDX_W-1:0]          cfg_index     = '0;
    logic [COEF_W-1:0]          cfg_data      = '0;
    logic                       in_valid      = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in     = '0;
    logic                       segment_start = 1'b0;
    logic                       out_valid;
    logic                       out_ready     = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;

    // filter model state
    logic signed [COEF_W-1:0]   coef_model [NUM_COEF];
    logic signed [SAMPLE_W-1:0] one_y1, one_y2, two_y1, two_y2;

    logic signed [SAMPLE_W-1:0] expected_samples [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         mismatch_count = 0;
    int                         tx_idle_pct    = 0;
    int                         rx_idle_pct    = 0;
    int                         rx_hold        = 0;
    int                         quiet_cycles   = 0;

    cascaded_formant_resonator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .segment_start (segment_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // One two-pole section: exact products, round half up, saturate
    function automatic logic signed [SAMPLE_W-1:0] section_out(
        input logic signed [SAMPLE_W-1:0] x,
        input logic signed [SAMPLE_W-1:0] y1,
        input logic signed [SAMPLE_W-1:0] y2,
        input logic signed [COEF_W-1:0]   g,
        input logic signed [COEF_W-1:0]   c1,
        input logic signed [COEF_W-1:0]   c2
    );
        longint                     acc;
        logic signed [SAMPLE_W-1:0] y;
        acc = longint'(g) * longint'(x) - longint'(c1) * longint'(y1)
            - longint'(c2) * longint'(y2);
        acc = (acc + (longint'(1) << (COEF_FRAC - 1))) >>> COEF_FRAC;
        if (acc > longint'(SAMPLE_TOP))
            y = SAMPLE_TOP;
        else if (acc < longint'(SAMPLE_BOTTOM))
            y = SAMPLE_BOTTOM;
        else
            y = acc[SAMPLE_W-1:0];
        return y;
    endfunction

    // Advance the model by one sample and queue the filtered result
    task automatic resonate(input logic signed [SAMPLE_W-1:0] x, input logic seg);
        logic signed [SAMPLE_W-1:0] mid;
        logic signed [SAMPLE_W-1:0] y;
        if (seg)
        begin
            one_y1 = '0;
            one_y2 = '0;
            two_y1 = '0;
            two_y2 = '0;
        end
        mid = section_out(x, one_y1, one_y2, coef_model[REG_GAIN_ONE],
                          coef_model[REG_FB1_ONE], coef_model[REG_FB2_ONE]);
        one_y2 = one_y1;
        one_y1 = mid;
        y = section_out(mid, two_y1, two_y2, coef_model[REG_GAIN_TWO],
                        coef_model[REG_FB1_TWO], coef_model[REG_FB2_TWO]);
        two_y2 = two_y1;
        two_y1 = y;
        expected_samples.push_back(y);
    endtask

    task automatic note_mismatch(input string what,
                                 input logic signed [SAMPLE_W-1:0] expected_val,
                                 input logic signed [SAMPLE_W-1:0] actual_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s sample_out expected %0d actual %0d",
                     $realtime, what, expected_val, actual_val);
    endtask

    // Offer one sample, hold it until the transfer, then predict
    task automatic feed_sample(input logic signed [SAMPLE_W-1:0] x, input logic seg);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        sample_in     = x;
        segment_start = seg;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        resonate(x, seg);
    endtask

    // Drop valid, wait for every pending result, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_samples.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_coef(input logic [CIDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        if (idx < NUM_COEF)
            coef_model[idx] = value;
    endtask

    task automatic write_all(input logic [COEF_W-1:0] g1, input logic [COEF_W-1:0] a1,
                             input logic [COEF_W-1:0] b1, input logic [COEF_W-1:0] g2,
                             input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] b2);
        write_coef(REG_GAIN_ONE, g1);
        write_coef(REG_FB1_ONE, a1);
        write_coef(REG_FB2_ONE, b1);
        write_coef(REG_GAIN_TWO, g2);
        write_coef(REG_FB1_TWO, a2);
        write_coef(REG_FB2_TWO, b2);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        logic signed [SAMPLE_W-1:0] s;
        int unsigned                roll;
        roll = $urandom_range(99);
        s = SAMPLE_W'($urandom);
        if (roll < 4)
            s = SAMPLE_TOP;
        else if (roll < 8)
            s = SAMPLE_BOTTOM;
        else if (roll < 30)
            s = s >>> 6;
        return s;
    endfunction

    // Mostly resonator-like values, with extremes and raw noise mixed in
    function automatic logic [COEF_W-1:0] pick_coef(input logic [CIDX_W-1:0] idx);
        int          v;
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            v = int'(COEF_TOP);
        else if (roll < 10)
            v = int'(COEF_BOTTOM);
        else if (roll < 14)
            v = 0;
        else if (roll < 34)
            v = int'($urandom);
        else if (idx == REG_GAIN_ONE || idx == REG_GAIN_TWO)
            v = int'($urandom_range(0, UNITY / 2)) - UNITY / 4;
        else if (idx == REG_FB1_ONE || idx == REG_FB1_TWO)
            v = int'($urandom_range(0, 4 * UNITY)) - 2 * UNITY;
        else
            v = int'($urandom_range(UNITY / 4, UNITY - 64));
        return v[COEF_W-1:0];
    endfunction

    task automatic randomize_coefs(input bit every_reg);
        for (int i = 0; i < NUM_COEF; i++)
            if (every_reg || $urandom_range(99) < 60)
                write_coef(i[CIDX_W-1:0], pick_coef(i[CIDX_W-1:0]));
    endtask

    // Reset coefficients are zero, so everything filters to zero
    task automatic test_zero_coefficients();
        feed_sample(SAMPLE_TOP, 1'b1);
        feed_sample(SAMPLE_BOTTOM, 1'b0);
        feed_sample('0, 1'b0);
        feed_sample(16'sd12345, 1'b0);
        wait_idle();
    endtask

    // Unity gains pass the input through; a half gain exercises rounding of halves
    task automatic test_unity_and_rounding();
        write_all(COEF_W'(UNITY), '0, '0, COEF_W'(UNITY), '0, '0);
        feed_sample(SAMPLE_TOP, 1'b1);
        feed_sample(SAMPLE_BOTTOM, 1'b0);
        feed_sample(-16'sd1, 1'b0);
        wait_idle();
        write_coef(REG_GAIN_ONE, COEF_W'(UNITY / 2));
        feed_sample(16'sd1, 1'b0);
        feed_sample(-16'sd1, 1'b0);
        feed_sample(16'sd3, 1'b0);
        feed_sample(-16'sd3, 1'b0);
        wait_idle();
    endtask

    // Overflow in each direction; saturated history feeds back
    task automatic test_saturation();
        write_all(COEF_TOP, '0, '0, COEF_W'(UNITY), '0, '0);
        feed_sample(SAMPLE_TOP, 1'b1);
        feed_sample(SAMPLE_BOTTOM, 1'b0);
        wait_idle();
        write_all(COEF_BOTTOM, COEF_BOTTOM, COEF_TOP, COEF_W'(UNITY), COEF_TOP, COEF_BOTTOM);
        feed_sample(SAMPLE_BOTTOM, 1'b0);
        feed_sample(SAMPLE_TOP, 1'b0);
        feed_sample('0, 1'b0);
        feed_sample('0, 1'b0);
        wait_idle();
    endtask

    // Ring a resonator, then clear its history in the middle of the decay
    task automatic test_segment_start();
        write_all(COEF_W'(UNITY / 2), COEF_W'(-(3 * UNITY / 2)), COEF_W'((9 * UNITY) / 10),
                  COEF_W'(UNITY / 2), COEF_W'(-(3 * UNITY / 2)), COEF_W'((9 * UNITY) / 10));
        feed_sample(16'sd20000, 1'b1);
        feed_sample('0, 1'b0);
        feed_sample('0, 1'b0);
        feed_sample('0, 1'b1);
        feed_sample(-16'sd20000, 1'b0);
        wait_idle();
    endtask

    // Writes beyond the register file must leave the coefficients alone
    task automatic test_unused_index();
        for (int i = NUM_COEF; i < (1 << CIDX_W); i++)
            write_coef(i[CIDX_W-1:0], COEF_W'($urandom));
        feed_sample(16'sd1000, 1'b1);
        feed_sample(SAMPLE_BOTTOM, 1'b0);
        wait_idle();
    endtask

    // Hold the output off while samples keep coming so the input stalls
    task automatic test_output_stall();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_idle();
        randomize_coefs(1'b1);
        @(posedge clk);
        rx_hold = STALL_CYCLES;
        feed_sample(random_sample(), 1'b1);
        repeat (39) feed_sample(random_sample(), 1'b0);
        wait_idle();
    endtask

    // Segments of random length under one idle pattern, new coefficients per block
    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int n_items);
        int left;
        int block_len;
        int seg_left;
        bit seg;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        left = n_items;
        seg_left = 0;
        while (left > 0)
        begin
            wait_idle();
            randomize_coefs(left == n_items);
            block_len = $urandom_range(60, 180);
            if (block_len > left)
                block_len = left;
            repeat (block_len)
            begin
                seg = (seg_left == 0) || ($urandom_range(99) < 2);
                if (seg_left == 0)
                    seg_left = $urandom_range(1, 80);
                seg_left--;
                feed_sample(random_sample(), seg);
                left--;
            end
        end
        wait_idle();
    endtask

    initial
    begin
        foreach (coef_model[i])
            coef_model[i] = '0;
        one_y1 = '0;
        one_y2 = '0;
        two_y1 = '0;
        two_y2 = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        tx_idle_pct = 30;
        rx_idle_pct = 30;
        test_zero_coefficients();
        test_unity_and_rounding();
        test_saturation();
        test_segment_start();
        test_unused_index();
        test_output_stall();
        test_random_traffic(9, 87, 630);
        test_random_traffic(87, 9, 630);
        test_random_traffic(0, 0, 630);

        wait_idle();
        if (mismatch_count == 0 && expected_samples.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Output side: random ready, or a forced hold-off
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready = 1'b0;
            rx_hold   = rx_hold - 1;
        end
        else
            out_ready = ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each output transfer with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
                note_mismatch("unexpected result:", '0, sample_out);
            else
            begin
                want = expected_samples.pop_front();
                if (sample_out !== want)
                    note_mismatch("mismatch:", want, sample_out);
            end
        end
    end

    // Abort when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
